### hdl/i2ssdw_pkg.sv
// shared types, constants and segment font for the digit write block
package i2ssdw_pkg;

  // input and result field widths
  localparam int VALUE_W = 32;
  localparam int ADDR_W  = 4;
  localparam int SEG_W   = 8;
  localparam int FRAME_W = 16;

  // decimal conversion sizes: 32 bits need ten bcd digits
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int SIG_W      = 4;
  localparam int STEP_W     = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

  // blank segment byte
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  // front sequencer states
  typedef enum logic [2:0] {
    FRONT_IDLE = 3'b001,
    FRONT_CONV = 3'b010,
    FRONT_PUSH = 3'b100
  } front_state_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // no-decode seven-segment font, bit 7 dp, bits 6..0 segments a..g
  function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
    logic [SEG_W-1:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h7E;
      4'd1:    pat = 8'h30;
      4'd2:    pat = 8'h6D;
      4'd3:    pat = 8'h79;
      4'd4:    pat = 8'h33;
      4'd5:    pat = 8'h5B;
      4'd6:    pat = 8'h5F;
      4'd7:    pat = 8'h70;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h7B;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

endpackage

### hdl/i2ssdw_front.sv
// front part: takes the value, converts its magnitude to bcd, counts digits
module i2ssdw_front #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [i2ssdw_pkg::VALUE_W-1:0] signed_value,
  output logic                                busy,
  input  i2ssdw_pkg::q_status_t               q_status,
  output logic                                push,
  output logic [i2ssdw_pkg::SIG_W+4*DIGIT_COUNT-1:0] push_data
);

  localparam int DW = 4 * DIGIT_COUNT;

  i2ssdw_pkg::front_state_t state, state_next;
  logic [i2ssdw_pkg::VALUE_W-1:0] bin;
  logic [i2ssdw_pkg::BCD_W-1:0]   bcd;
  logic [i2ssdw_pkg::STEP_W-1:0]  step;
  logic [i2ssdw_pkg::BCD_W-1:0]   bcd_adj;
  logic [i2ssdw_pkg::VALUE_W-1:0] magnitude;
  logic [i2ssdw_pkg::SIG_W-1:0]   sig;
  logic                           accept;

  assign accept = start && (state == i2ssdw_pkg::FRONT_IDLE);
  assign busy   = (state != i2ssdw_pkg::FRONT_IDLE);
  assign push   = (state == i2ssdw_pkg::FRONT_PUSH) && !q_status.full;

  // magnitude, most negative value wraps to its unsigned form
  assign magnitude = signed_value[i2ssdw_pkg::VALUE_W-1]
                   ? (i2ssdw_pkg::VALUE_W'(0) - i2ssdw_pkg::VALUE_W'(signed_value))
                   : i2ssdw_pkg::VALUE_W'(signed_value);

  // add-three correction on every bcd digit
  always_comb begin
    for (int i = 0; i < i2ssdw_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // number of significant digits, at least one
  always_comb begin
    sig = i2ssdw_pkg::SIG_W'(1);
    for (int i = 1; i < i2ssdw_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        sig = i2ssdw_pkg::SIG_W'(i + 1);
      end
    end
  end

  assign push_data = {sig, bcd[DW-1:0]};

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      i2ssdw_pkg::FRONT_IDLE: if (start) state_next = i2ssdw_pkg::FRONT_CONV;
      i2ssdw_pkg::FRONT_CONV: begin
        if (step == i2ssdw_pkg::LAST_STEP) state_next = i2ssdw_pkg::FRONT_PUSH;
      end
      i2ssdw_pkg::FRONT_PUSH: if (!q_status.full) state_next = i2ssdw_pkg::FRONT_IDLE;
      default: state_next = i2ssdw_pkg::FRONT_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2ssdw_pkg::FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shift-and-add-three datapath, one bit per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      bin  <= magnitude;
      bcd  <= '0;
      step <= '0;
    end else if (state == i2ssdw_pkg::FRONT_CONV) begin
      {bcd, bin} <= {bcd_adj[i2ssdw_pkg::BCD_W-2:0], bin, 1'b0};
      step       <= step + i2ssdw_pkg::STEP_W'(1);
    end
  end

endmodule

### hdl/i2ssdw_queue.sv
// two-entry queue between the front and back parts
module i2ssdw_queue #(
  parameter int WIDTH = 36
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output i2ssdw_pkg::q_status_t status
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign status.empty = (count == 2'd0);
  assign status.full  = (count == 2'd2);
  assign pop_data     = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end else begin
        count <= count;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule

### hdl/i2ssdw_back.sv
// back part: issues one digit register write per cycle for each queued number
module i2ssdw_back #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  i2ssdw_pkg::q_status_t                        q_status,
  input  logic [i2ssdw_pkg::SIG_W+4*DIGIT_COUNT-1:0]   pop_data,
  output logic                                         pop,
  output logic                                         strobe,
  output logic [i2ssdw_pkg::ADDR_W-1:0]                digit_address,
  output logic [i2ssdw_pkg::SEG_W-1:0]                 segment_pattern,
  output logic [i2ssdw_pkg::FRAME_W-1:0]               frame_word,
  output logic                                         last_write
);

  localparam int DW = 4 * DIGIT_COUNT;
  localparam logic [i2ssdw_pkg::ADDR_W-1:0] LAST_K =
    i2ssdw_pkg::ADDR_W'(DIGIT_COUNT - 1);

  logic                          active;
  logic [DW-1:0]                 digits;
  logic [i2ssdw_pkg::SIG_W-1:0]  sig;
  logic [i2ssdw_pkg::ADDR_W-1:0] k;
  logic [3:0]                    cur_digit;
  logic [i2ssdw_pkg::SEG_W-1:0]  pat;
  logic [i2ssdw_pkg::ADDR_W-1:0] addr;
  logic                          is_last;

  assign pop = !active && !q_status.empty;

  // current digit, blanked above the significant ones
  assign cur_digit = 4'(digits >> {k, 2'b00});
  assign pat       = (k >= sig) ? i2ssdw_pkg::SEG_BLANK : i2ssdw_pkg::seg_font(cur_digit);
  assign addr      = k + i2ssdw_pkg::ADDR_W'(1);
  assign is_last   = (k == LAST_K);

  // run control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (active && is_last) begin
        active <= 1'b0;
      end
    end
  end

  // run data and digit counter
  always_ff @(posedge clk) begin
    if (pop) begin
      {sig, digits} <= pop_data;
      k             <= '0;
    end else if (active) begin
      k <= k + i2ssdw_pkg::ADDR_W'(1);
    end
  end

  // registered write outputs
  always_ff @(posedge clk) begin
    if (active) begin
      digit_address   <= addr;
      segment_pattern <= pat;
      frame_word      <= {{(i2ssdw_pkg::FRAME_W - i2ssdw_pkg::SEG_W - i2ssdw_pkg::ADDR_W){1'b0}},
                          addr, pat};
      last_write      <= is_last;
    end
  end

endmodule

### hdl/integer_to_seven_segment_digit_writes.sv
// top level: signed integer to eight digit register writes for a segment display
//
//   channel  | handshake      | fields
//   ---------+----------------+-----------------------------------------------
//   input    | start / busy   | signed_value
//   result   | strobe         | digit_address, segment_pattern, frame_word,
//            |                | last_write
//
// A number is taken when start is high and busy low; busy then stays high
// through 32 shift-and-add-three steps, one per input bit, and the push into
// the queue, which waits while the two-entry queue is full.
// Each queued number gives DIGIT_COUNT writes on consecutive cycles; the next
// run starts once the back part pops the next number; results cannot be held off.
// Synchronous reset empties the queue and idles both parts.
module integer_to_seven_segment_digit_writes #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [i2ssdw_pkg::VALUE_W-1:0] signed_value,
  output logic                                  strobe,
  output logic [i2ssdw_pkg::ADDR_W-1:0]         digit_address,
  output logic [i2ssdw_pkg::SEG_W-1:0]          segment_pattern,
  output logic [i2ssdw_pkg::FRAME_W-1:0]        frame_word,
  output logic                                  last_write
);

  localparam int QW = i2ssdw_pkg::SIG_W + 4 * DIGIT_COUNT;

  i2ssdw_pkg::q_status_t q_status;
  logic                  push;
  logic                  pop;
  logic [QW-1:0]         push_data;
  logic [QW-1:0]         pop_data;

  // conversion front
  i2ssdw_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .signed_value (signed_value),
    .busy         (busy),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  // queue between front and back
  i2ssdw_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // write issue back
  i2ssdw_back #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_status        (q_status),
    .pop_data        (pop_data),
    .pop             (pop),
    .strobe          (strobe),
    .digit_address   (digit_address),
    .segment_pattern (segment_pattern),
    .frame_word      (frame_word),
    .last_write      (last_write)
  );

endmodule

### test/digit_write_checker.sv
// checker that predicts and compares the digit writes of the display block
`timescale 1ns / 100ps

module digit_write_checker #(
  parameter int DIGITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic signed [i2ssdw_pkg::VALUE_W-1:0] signed_value,
  input  logic                                  strobe,
  input  logic [i2ssdw_pkg::ADDR_W-1:0]         digit_address,
  input  logic [i2ssdw_pkg::SEG_W-1:0]          segment_pattern,
  input  logic [i2ssdw_pkg::FRAME_W-1:0]        frame_word,
  input  logic                                  last_write,
  output int                                    fail_count,
  output int                                    pending_writes,
  output int                                    accepted_values,
  output int                                    observed_writes
);

  // one digit register write as seen on the result ports
  typedef struct packed {
    logic [i2ssdw_pkg::ADDR_W-1:0]  addr;
    logic [i2ssdw_pkg::SEG_W-1:0]   seg;
    logic [i2ssdw_pkg::FRAME_W-1:0] frame;
    logic                           last;
  } digit_write_t;

  // no-decode font for digits 0..9
  localparam logic [i2ssdw_pkg::SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };

  digit_write_t expected_writes[$];

  initial begin
    fail_count      = 0;
    pending_writes  = 0;
    accepted_values = 0;
    observed_writes = 0;
  end

  // magnitude split into decimal digits, low digit first, leading zeros blanked
  function automatic void predict_digit_writes(input logic [i2ssdw_pkg::VALUE_W-1:0] raw);
    logic [i2ssdw_pkg::VALUE_W-1:0] mag;
    logic [i2ssdw_pkg::SEG_W-1:0]   seg;
    digit_write_t                   w;
    mag = raw[i2ssdw_pkg::VALUE_W-1] ? -raw : raw;
    for (int k = 0; k < DIGITS; k++) begin
      if (k != 0 && mag == 0) begin
        seg = i2ssdw_pkg::SEG_BLANK;
      end else begin
        seg = DIGIT_SEGMENTS[4'(mag % 10)];
        mag = mag / 10;
      end
      w.addr  = i2ssdw_pkg::ADDR_W'(k + 1);
      w.seg   = seg;
      w.frame = {8'(k + 1), seg};
      w.last  = (k == DIGITS - 1);
      expected_writes.push_back(w);
    end
  endfunction

  // compare each strobed write with the oldest expectation, then take new transactions
  always @(posedge clk) begin : watch
    digit_write_t want;
    if (!rst) begin
      if (strobe) begin
        observed_writes++;
        if (expected_writes.size() == 0) begin
          $error("unexpected digit write: address %0d pattern %h", digit_address,
                 segment_pattern);
          fail_count++;
        end else begin
          want = expected_writes.pop_front();
          if (digit_address !== want.addr) begin
            $error("digit_address: expected %0d, got %0d", want.addr, digit_address);
            fail_count++;
          end
          if (segment_pattern !== want.seg) begin
            $error("segment_pattern: expected %h, got %h", want.seg, segment_pattern);
            fail_count++;
          end
          if (frame_word !== want.frame) begin
            $error("frame_word: expected %h, got %h", want.frame, frame_word);
            fail_count++;
          end
          if (last_write !== want.last) begin
            $error("last_write: expected %b, got %b", want.last, last_write);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        accepted_values++;
        predict_digit_writes(signed_value);
      end
    end
    pending_writes = expected_writes.size();
  end

endmodule

### test/tb_integer_to_seven_segment_digit_writes.sv
// testbench top: stimulus, clock, reset and verdict for the digit write block
`timescale 1ns / 100ps

module tb_integer_to_seven_segment_digit_writes;

  localparam int DIGIT_COUNT  = 8;
  localparam int RANDOM_ITEMS = 420;
  localparam int CYCLE_LIMIT  = 400000;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  start = 1'b0;
  logic signed [i2ssdw_pkg::VALUE_W-1:0] signed_value = '0;
  logic                                  busy;
  logic                                  strobe;
  logic [i2ssdw_pkg::ADDR_W-1:0]         digit_address;
  logic [i2ssdw_pkg::SEG_W-1:0]          segment_pattern;
  logic [i2ssdw_pkg::FRAME_W-1:0]        frame_word;
  logic                                  last_write;

  int fail_count;
  int pending_writes;
  int accepted_values;
  int observed_writes;
  int cycle_count = 0;

  integer_to_seven_segment_digit_writes #(.DIGIT_COUNT(DIGIT_COUNT)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .signed_value(signed_value),
    .strobe(strobe), .digit_address(digit_address), .segment_pattern(segment_pattern),
    .frame_word(frame_word), .last_write(last_write)
  );

  digit_write_checker #(.DIGITS(DIGIT_COUNT)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .signed_value(signed_value),
    .strobe(strobe), .digit_address(digit_address), .segment_pattern(segment_pattern),
    .frame_word(frame_word), .last_write(last_write), .fail_count(fail_count),
    .pending_writes(pending_writes), .accepted_values(accepted_values),
    .observed_writes(observed_writes)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // present one value and hold it until the block takes the transaction
  task automatic send_value(input logic [i2ssdw_pkg::VALUE_W-1:0] v);
    start        <= 1'b1;
    signed_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // drop start and wait for the given gap between bursts
  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // value with a random count of decimal digits and a random sign
  function automatic logic [i2ssdw_pkg::VALUE_W-1:0] random_value();
    int unsigned                    ndig;
    int unsigned                    limit;
    logic [i2ssdw_pkg::VALUE_W-1:0] v;
    ndig = $urandom_range(1, 10);
    if (ndig == 10) begin
      v = $urandom;
    end else begin
      limit = 1;
      repeat (ndig) limit = limit * 10;
      v = $urandom_range(0, limit - 1);
      if ($urandom_range(0, 1)) v = -v;
    end
    return v;
  endfunction

  logic [i2ssdw_pkg::VALUE_W-1:0] directed_values [$] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, 32'd7, 32'd5000, 32'd1000000,
    32'd10000000, 32'd12345678, -32'sd12345678, 32'd87654321, 32'd90909090,
    32'd99999999, 32'd100000000, 32'd123456789, -32'sd2, 32'd2147483647,
    -32'sd2147483647, 32'h8000_0000, 32'd4294967295, 32'hFFFF_FFF6
  };

  initial begin : stimulus
    int sent;
    int burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed values back to back: extremes, zero, blanking and digit overflow
    foreach (directed_values[i]) send_value(directed_values[i]);
    idle_gap($urandom_range(0, 40));

    // random bursts with random gaps; one full drain halfway through
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        send_value(random_value());
        sent++;
      end
      if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending_writes != 0) @(posedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        idle_gap($urandom_range(1, 80));
      end
    end
    start <= 1'b0;

    // drain and let the block settle
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("displayed %0d values, checked %0d digit writes", accepted_values,
             observed_writes);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
